@@ src/uapq_pkg.sv @@
// Shared types and constants for the unsorted array priority queue.
`timescale 1ns / 1ps
`default_nettype none
package uapq_pkg;

	localparam int DEPTH_DEFAULT = 64;

	localparam int MODE_W   = 3;
	localparam int ELEM_W   = 16;
	localparam int PRIO_W   = 16;
	localparam int STATUS_W = 2;
	localparam int RIDX_W   = 6;
	localparam int RCNT_W   = 7;
	localparam int CFG_W    = 7;

	localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

	localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_TOP    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;       // latch the operation of a start transfer
		logic top_read;   // read the entry at the top index
		logic scan_init;  // clear the scan pointers and trackers
		logic scan_step;  // advance the scan by one entry
		logic finish;     // commit the operation and present its result
	} cmd_t;

	typedef struct packed {
		logic scan_done;
	} stat_t;

endpackage
`default_nettype wire

@@ src/unsorted_array_priority_queue.sv @@
// Insert, top and unused modes pass through the finish state, which commits the operation.
// Pop, remove and update commit after a scan: the single read port of the entry memory walks
// every held entry once, one a cycle, shifting (pop, remove) and rescanning in the same pass.
// A new start transfer is taken in the cycle the result strobe is high; results cannot stall.
// Reset clears the count, the top index, the controller and sets capacity to 64;
// the entry memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module unsorted_array_priority_queue #(
	parameter int DEPTH = uapq_pkg::DEPTH_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [uapq_pkg::MODE_W-1:0]   mode,
	input  wire logic [uapq_pkg::ELEM_W-1:0]   element_id,
	input  wire logic [uapq_pkg::PRIO_W-1:0]   priority_req,
	input  wire logic                          cfg_we,
	input  wire logic [uapq_pkg::CFG_W-1:0]    cfg_wdata,
	output logic                               done,
	output logic [uapq_pkg::STATUS_W-1:0]      status,
	output logic [uapq_pkg::ELEM_W-1:0]        result_element,
	output logic [uapq_pkg::RIDX_W-1:0]        result_index,
	output logic [uapq_pkg::RCNT_W-1:0]        entry_count
);

	uapq_pkg::cmd_t  cmd;
	uapq_pkg::stat_t stat;

	uapq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	uapq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.mode           (mode),
		.element_id     (element_id),
		.priority_req   (priority_req),
		.cmd            (cmd),
		.stat           (stat),
		.done           (done),
		.status         (status),
		.result_element (result_element),
		.result_index   (result_index),
		.entry_count    (entry_count)
	);

`ifndef NO_ASSERTIONS
	// Every accepted transfer keeps the block busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after an accepted start");

	// The block leaves its busy period only by delivering a result.
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// A result is only shown once the controller has returned to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// The commit command always produces a result strobe in the next cycle.
	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> done)
		else $error("commit without a result strobe");
`endif

endmodule
`default_nettype wire

@@ src/uapq_ctrl.sv @@
// Controller state machine for the unsorted array priority queue.
`timescale 1ns / 1ps
`default_nettype none
module uapq_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [uapq_pkg::MODE_W-1:0] mode,
	input  wire uapq_pkg::stat_t             stat,
	output logic                             busy,
	output uapq_pkg::cmd_t                   cmd
);

	uapq_pkg::state_t state_q;
	uapq_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uapq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			uapq_pkg::ST_IDLE: begin
				if (start) begin
					if (mode inside {uapq_pkg::MODE_POP, uapq_pkg::MODE_REMOVE,
							uapq_pkg::MODE_UPDATE}) begin
						state_nxt = uapq_pkg::ST_SCAN;
					end else begin
						state_nxt = uapq_pkg::ST_FINISH;
					end
				end
			end
			uapq_pkg::ST_SCAN: begin
				if (stat.scan_done) begin
					state_nxt = uapq_pkg::ST_IDLE;
				end
			end
			uapq_pkg::ST_FINISH: begin
				state_nxt = uapq_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = uapq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			uapq_pkg::ST_IDLE: begin
				busy          = 1'b0;
				cmd.load      = start;
				cmd.scan_init = start;
				cmd.top_read  = start && (mode == uapq_pkg::MODE_TOP);
			end
			uapq_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.finish    = stat.scan_done;
			end
			uapq_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ src/uapq_dp.sv @@
// Datapath of the unsorted array priority queue: entry memory, scan and results.
`timescale 1ns / 1ps
`default_nettype none
module uapq_dp #(
	parameter int DEPTH = uapq_pkg::DEPTH_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [uapq_pkg::CFG_W-1:0]    cfg_wdata,
	input  wire logic [uapq_pkg::MODE_W-1:0]   mode,
	input  wire logic [uapq_pkg::ELEM_W-1:0]   element_id,
	input  wire logic [uapq_pkg::PRIO_W-1:0]   priority_req,
	input  wire uapq_pkg::cmd_t                cmd,
	output uapq_pkg::stat_t                    stat,
	output logic                               done,
	output logic [uapq_pkg::STATUS_W-1:0]      status,
	output logic [uapq_pkg::ELEM_W-1:0]        result_element,
	output logic [uapq_pkg::RIDX_W-1:0]        result_index,
	output logic [uapq_pkg::RCNT_W-1:0]        entry_count
);

	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = (CNT_W > uapq_pkg::CFG_W) ? CNT_W : uapq_pkg::CFG_W;
	localparam int IDXX_W = (IDX_W > uapq_pkg::RIDX_W) ? IDX_W : uapq_pkg::RIDX_W;
	localparam int CNTX_W = (CNT_W > uapq_pkg::RCNT_W) ? CNT_W : uapq_pkg::RCNT_W;

	// Configuration and operation registers.
	logic [uapq_pkg::CFG_W-1:0]    capacity_q;
	logic [uapq_pkg::MODE_W-1:0]   op_mode_q;
	logic [uapq_pkg::ELEM_W-1:0]   op_id_q;
	logic [uapq_pkg::PRIO_W-1:0]   op_prio_q;

	// Queue bookkeeping.
	logic [CNT_W-1:0]              count_q;
	logic [IDX_W-1:0]              highest_q;
	logic [uapq_pkg::PRIO_W-1:0]   best_prio_q;

	// Entry memory with registered read data.
	logic [uapq_pkg::ELEM_W-1:0]   mem_elem [DEPTH];
	logic [uapq_pkg::PRIO_W-1:0]   mem_prio [DEPTH];
	logic [uapq_pkg::ELEM_W-1:0]   rd_elem_q;
	logic [uapq_pkg::PRIO_W-1:0]   rd_prio_q;

	// Scan pointers and trackers.
	logic [CNT_W-1:0]              issue_ptr_q;
	logic                          vld_s1;
	logic [IDX_W-1:0]              ptr_s1;
	logic                          found_q;
	logic [IDX_W-1:0]              match_idx_q;
	logic [uapq_pkg::ELEM_W-1:0]   match_elem_q;
	logic [uapq_pkg::PRIO_W-1:0]   new_best_q;
	logic [IDX_W-1:0]              new_high_q;

	// Result registers.
	logic                          done_q;
	logic [uapq_pkg::STATUS_W-1:0] status_q;
	logic [uapq_pkg::ELEM_W-1:0]   res_elem_q;
	logic [IDX_W-1:0]              res_idx_q;

	logic                          op_pop;
	logic                          op_del;
	logic                          op_upd;
	logic                          hit;
	logic                          kept;
	logic [IDX_W-1:0]              new_pos;
	logic [uapq_pkg::PRIO_W-1:0]   cand_prio;
	logic                          take;
	logic                          issue_now;
	logic                          full;
	logic [CMP_W-1:0]              cap_ext;
	logic [CMP_W-1:0]              depth_ext;
	logic [CMP_W-1:0]              limit;
	logic [CMP_W-1:0]              count_ext;
	logic                          rd_en;
	logic [IDX_W-1:0]              rd_addr;
	logic                          wr_en;
	logic [IDX_W-1:0]              wr_addr;
	logic [uapq_pkg::ELEM_W-1:0]   wr_elem;
	logic [uapq_pkg::PRIO_W-1:0]   wr_prio;
	logic [IDXX_W-1:0]             ridx_ext;
	logic [CNTX_W-1:0]             rcnt_ext;

	assign op_pop = (op_mode_q == uapq_pkg::MODE_POP);
	assign op_del = op_pop || (op_mode_q == uapq_pkg::MODE_REMOVE);
	assign op_upd = (op_mode_q == uapq_pkg::MODE_UPDATE);

	assign cap_ext   = CMP_W'(capacity_q);
	assign depth_ext = CMP_W'(DEPTH);
	assign count_ext = CMP_W'(count_q);
	assign limit     = (cap_ext < depth_ext) ? cap_ext : depth_ext;
	assign full      = (count_ext >= limit);

	// A pop targets the top index; remove and update target the first matching id.
	assign hit = vld_s1 && !found_q &&
		(op_pop ? (ptr_s1 == highest_q) : (rd_elem_q == op_id_q));
	assign kept      = !(op_del && hit);
	assign new_pos   = (op_del && found_q) ? (ptr_s1 - IDX_W'(1)) : ptr_s1;
	assign cand_prio = (op_upd && hit) ? op_prio_q : rd_prio_q;
	assign take      = vld_s1 && kept && ((new_pos == '0) || (cand_prio > new_best_q));

	assign issue_now = cmd.scan_step && (issue_ptr_q != count_q);
	assign stat.scan_done = (issue_ptr_q == count_q) && !vld_s1;

	assign rd_en   = cmd.top_read || issue_now;
	assign rd_addr = cmd.top_read ? highest_q : issue_ptr_q[IDX_W-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_s1;
		wr_elem = rd_elem_q;
		wr_prio = rd_prio_q;
		if (cmd.finish && (op_mode_q == uapq_pkg::MODE_INSERT) && !full) begin
			wr_en   = 1'b1;
			wr_addr = count_q[IDX_W-1:0];
			wr_elem = op_id_q;
			wr_prio = op_prio_q;
		end else if (vld_s1 && op_del && found_q) begin
			// Entries behind the removed one move down by one place.
			wr_en   = 1'b1;
			wr_addr = ptr_s1 - IDX_W'(1);
		end else if (vld_s1 && op_upd && hit) begin
			wr_en   = 1'b1;
			wr_prio = op_prio_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_elem[wr_addr] <= wr_elem;
			mem_prio[wr_addr] <= wr_prio;
		end
		if (rd_en) begin
			rd_elem_q <= mem_elem[rd_addr];
			rd_prio_q <= mem_prio[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= uapq_pkg::CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_mode_q <= mode;
			op_id_q   <= element_id;
			op_prio_q <= priority_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_ptr_q <= '0;
			vld_s1      <= 1'b0;
			found_q     <= 1'b0;
		end else if (cmd.scan_init) begin
			issue_ptr_q <= '0;
			vld_s1      <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			vld_s1 <= issue_now;
			if (issue_now) begin
				issue_ptr_q <= issue_ptr_q + CNT_W'(1);
			end
			if (hit) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue_now) begin
			ptr_s1 <= issue_ptr_q[IDX_W-1:0];
		end
		if (cmd.scan_init) begin
			new_best_q <= '0;
			new_high_q <= '0;
		end else if (take) begin
			new_best_q <= cand_prio;
			new_high_q <= new_pos;
		end
		if (hit) begin
			match_idx_q  <= ptr_s1;
			match_elem_q <= rd_elem_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			highest_q   <= '0;
			best_prio_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.finish) begin
				case (op_mode_q)
					uapq_pkg::MODE_INSERT: begin
						if (!full) begin
							count_q <= count_q + CNT_W'(1);
							if ((count_q == '0) || (op_prio_q > best_prio_q)) begin
								highest_q   <= count_q[IDX_W-1:0];
								best_prio_q <= op_prio_q;
							end
						end
					end
					uapq_pkg::MODE_POP, uapq_pkg::MODE_REMOVE, uapq_pkg::MODE_UPDATE: begin
						if (found_q) begin
							if (op_del) begin
								count_q <= count_q - CNT_W'(1);
							end
							highest_q   <= new_high_q;
							best_prio_q <= new_best_q;
						end
					end
					default: begin
						count_q <= count_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q   <= uapq_pkg::STAT_OK;
			res_elem_q <= op_id_q;
			res_idx_q  <= '0;
			case (op_mode_q)
				uapq_pkg::MODE_INSERT: begin
					if (full) begin
						status_q <= uapq_pkg::STAT_FULL;
					end else begin
						res_idx_q <= count_q[IDX_W-1:0];
					end
				end
				uapq_pkg::MODE_TOP: begin
					if (count_q == '0) begin
						status_q   <= uapq_pkg::STAT_EMPTY;
						res_elem_q <= '0;
					end else begin
						res_elem_q <= rd_elem_q;
						res_idx_q  <= highest_q;
					end
				end
				uapq_pkg::MODE_POP: begin
					if (found_q) begin
						res_elem_q <= match_elem_q;
						res_idx_q  <= match_idx_q;
					end else begin
						status_q   <= uapq_pkg::STAT_EMPTY;
						res_elem_q <= '0;
					end
				end
				uapq_pkg::MODE_REMOVE, uapq_pkg::MODE_UPDATE: begin
					if (found_q) begin
						res_idx_q <= match_idx_q;
					end else begin
						status_q <= uapq_pkg::STAT_NOTFOUND;
					end
				end
				default: begin
					status_q <= uapq_pkg::STAT_OK;
				end
			endcase
		end
	end

	assign ridx_ext = IDXX_W'(res_idx_q);
	assign rcnt_ext = CNTX_W'(count_q);

	assign done           = done_q;
	assign status         = status_q;
	assign result_element = res_elem_q;
	assign result_index   = ridx_ext[uapq_pkg::RIDX_W-1:0];
	assign entry_count    = rcnt_ext[uapq_pkg::RCNT_W-1:0];

endmodule
`default_nettype wire

@@ test/tb.sv @@
// Testbench for the unsorted array priority queue: queued operations, a shadow model, result checks.
`timescale 1ns / 1ps
module tb;
	import uapq_pkg::*;

	localparam int DEPTH = DEPTH_DEFAULT;
	localparam int IDLE_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 4;
	localparam int END_CYCLES = 80;

	// Modes five to seven do nothing in the block.
	localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [ELEM_W-1:0] element;
		logic [PRIO_W-1:0] prio;
	} op_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ELEM_W-1:0]   element;
		logic [RIDX_W-1:0]   index;
		logic [RCNT_W-1:0]   count;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [MODE_W-1:0] mode = MODE_INSERT;
	logic [ELEM_W-1:0] element_id = '0;
	logic [PRIO_W-1:0] priority_req = '0;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = CAP_RESET;
	logic busy;
	logic done;
	logic [STATUS_W-1:0] status;
	logic [ELEM_W-1:0] result_element;
	logic [RIDX_W-1:0] result_index;
	logic [RCNT_W-1:0] entry_count;

	unsorted_array_priority_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.element_id(element_id),
		.priority_req(priority_req),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.status(status),
		.result_element(result_element),
		.result_index(result_index),
		.entry_count(entry_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the queue contents and the capacity register.
	logic [ELEM_W-1:0] q_elem [DEPTH];
	logic [PRIO_W-1:0] q_prio [DEPTH];
	int q_count = 0;
	int q_top = 0;
	int q_cap = int'(CAP_RESET);

	op_t pending_ops [$];
	result_t expected_results [$];
	logic [ELEM_W-1:0] id_pool [16];

	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	int cap_writes = 0;
	int max_depth = 0;
	int mode_seen [8];
	int status_seen [4];
	op_t drv_op;
	result_t mon_want;

	function automatic void find_top();
		int best;
		best = 0;
		q_top = 0;
		for (int i = 0; i < q_count; i++) begin
			if (i == 0 || int'(q_prio[i]) > best) begin
				best = int'(q_prio[i]);
				q_top = i;
			end
		end
	endfunction

	function automatic void remove_entry(int pos);
		for (int i = pos; i + 1 < q_count; i++) begin
			q_elem[i] = q_elem[i + 1];
			q_prio[i] = q_prio[i + 1];
		end
		if (q_count > 0)
			q_count--;
		find_top();
	endfunction

	function automatic int find_entry(logic [ELEM_W-1:0] id);
		for (int i = 0; i < q_count; i++)
			if (q_elem[i] == id)
				return i;
		return -1;
	endfunction

	function automatic result_t apply_op(op_t op);
		result_t r;
		int limit;
		int pos;
		logic [PRIO_W-1:0] old_prio;
		r.status = STAT_OK;
		r.element = op.element;
		r.index = '0;
		limit = (q_cap < DEPTH) ? q_cap : DEPTH;
		case (op.mode)
			MODE_INSERT: begin
				if (q_count >= limit) begin
					r.status = STAT_FULL;
				end else begin
					r.index = RIDX_W'(q_count);
					q_elem[q_count] = op.element;
					q_prio[q_count] = op.prio;
					if (q_count == 0 || op.prio > q_prio[q_top])
						q_top = q_count;
					q_count++;
				end
			end
			MODE_TOP, MODE_POP: begin
				if (q_count == 0) begin
					r.status = STAT_EMPTY;
					r.element = '0;
				end else begin
					r.index = RIDX_W'(q_top);
					r.element = q_elem[q_top];
					if (op.mode == MODE_POP)
						remove_entry(q_top);
				end
			end
			MODE_REMOVE: begin
				pos = find_entry(op.element);
				if (pos < 0) begin
					r.status = STAT_NOTFOUND;
				end else begin
					r.index = RIDX_W'(pos);
					remove_entry(pos);
				end
			end
			MODE_UPDATE: begin
				pos = find_entry(op.element);
				if (pos < 0) begin
					r.status = STAT_NOTFOUND;
				end else begin
					old_prio = q_prio[pos];
					r.index = RIDX_W'(pos);
					q_prio[pos] = op.prio;
					// Only a fallen top or a risen non-top entry can move the maximum.
					if ((pos == q_top && old_prio > op.prio) ||
							(pos != q_top && old_prio < op.prio))
						find_top();
				end
			end
			default: ;
		endcase
		r.count = RCNT_W'(q_count);
		return r;
	endfunction

	function automatic op_t random_op(int insert_pct);
		op_t op;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < insert_pct) begin
			op.mode = MODE_INSERT;
		end else begin
			pick = $urandom_range(0, 19);
			if (pick < 4)
				op.mode = MODE_TOP;
			else if (pick < 9)
				op.mode = MODE_POP;
			else if (pick < 14)
				op.mode = MODE_REMOVE;
			else if (pick < 19)
				op.mode = MODE_UPDATE;
			else begin
				pick = $urandom_range(0, 2);
				op.mode = (pick == 0) ? MODE_SPARE_A : (pick == 1) ? MODE_SPARE_B : MODE_SPARE_C;
			end
		end
		// A small id pool makes removes and updates hit, and yields duplicate ids.
		if ($urandom_range(0, 99) < 85)
			op.element = id_pool[$urandom_range(0, 15)];
		else
			op.element = ELEM_W'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 4)
			op.prio = PRIO_W'($urandom_range(0, 7));
		else if (pick == 4)
			op.prio = $urandom_range(0, 1) ? '1 : '0;
		else
			op.prio = PRIO_W'($urandom);
		return op;
	endfunction

	task automatic push_op(logic [MODE_W-1:0] m, logic [ELEM_W-1:0] id, logic [PRIO_W-1:0] p);
		op_t op;
		op.mode = m;
		op.element = id;
		op.prio = p;
		pending_ops.push_back(op);
	endtask

	task automatic wait_drained(int settle);
		while (pending_ops.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_capacity(int value);
		wait_drained(SETTLE_CYCLES);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= CFG_W'(value);
		q_cap = value;
		cap_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_phase(int cap, int items, int insert_pct);
		write_capacity(cap);
		for (int i = 0; i < items; i++)
			pending_ops.push_back(random_op(insert_pct));
	endtask

	// Driver: presents queued operations in bursts and updates the shadow model on each transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				drv_op = pending_ops.pop_front();
				expected_results.push_back(apply_op(drv_op));
				mode_seen[drv_op.mode]++;
				if (q_count > max_depth)
					max_depth = q_count;
			end
			if (start && busy) begin
				// Hold the current operation until the block takes it.
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_ops.size() > 0) begin
				start <= 1'b1;
				mode <= pending_ops[0].mode;
				element_id <= pending_ops[0].element;
				priority_req <= pending_ops[0].prio;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every strobed result must match the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with no operation outstanding: status %0d element %0h",
					status, result_element);
				errors++;
			end else begin
				mon_want = expected_results.pop_front();
				status_seen[mon_want.status]++;
				if (status !== mon_want.status) begin
					$error("status: expected %0d, got %0d", mon_want.status, status);
					errors++;
				end
				if (result_element !== mon_want.element) begin
					$error("result_element: expected %0h, got %0h", mon_want.element,
						result_element);
					errors++;
				end
				if (result_index !== mon_want.index) begin
					$error("result_index: expected %0d, got %0d", mon_want.index, result_index);
					errors++;
				end
				if (entry_count !== mon_want.count) begin
					$error("entry_count: expected %0d, got %0d", mon_want.count, entry_count);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < 8; i++)
			mode_seen[i] = 0;
		for (int i = 0; i < 4; i++)
			status_seen[i] = 0;
		id_pool[0] = '0;
		id_pool[1] = '1;
		for (int i = 2; i < 16; i++)
			id_pool[i] = ELEM_W'($urandom);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty queue, ties at the maximum, duplicate ids, both kinds of rescan.
		push_op(MODE_TOP, 16'h0000, 16'h0000);
		push_op(MODE_POP, 16'h0000, 16'h0000);
		push_op(MODE_REMOVE, 16'h1234, 16'h0000);
		push_op(MODE_UPDATE, 16'hFFFF, 16'hFFFF);
		push_op(MODE_INSERT, 16'h0000, 16'h0000);
		push_op(MODE_INSERT, 16'hFFFF, 16'hFFFF);
		push_op(MODE_INSERT, 16'h1234, 16'hFFFF);
		push_op(MODE_INSERT, 16'h1234, 16'h0005);
		push_op(MODE_TOP, 16'h0000, 16'h0000);
		push_op(MODE_UPDATE, 16'h1234, 16'h0000);
		push_op(MODE_UPDATE, 16'hFFFF, 16'h0001);
		push_op(MODE_SPARE_A, 16'hAAAA, 16'h5555);
		push_op(MODE_SPARE_C, 16'hFFFF, 16'hFFFF);
		push_op(MODE_REMOVE, 16'h1234, 16'h0000);
		push_op(MODE_UPDATE, 16'h0000, 16'hFFFF);
		push_op(MODE_POP, 16'h0000, 16'h0000);
		push_op(MODE_REMOVE, 16'h5555, 16'h0000);
		push_op(MODE_POP, 16'h0000, 16'h0000);
		push_op(MODE_POP, 16'h0000, 16'h0000);
		push_op(MODE_INSERT, 16'h00FF, 16'h8000);
		push_op(MODE_TOP, 16'h0000, 16'h0000);

		// Capacity extremes, including a capacity below the current count.
		write_capacity(0);
		push_op(MODE_INSERT, 16'h0001, 16'h0007);
		write_capacity(1);
		push_op(MODE_POP, 16'h0000, 16'h0000);
		push_op(MODE_INSERT, 16'h0002, 16'h0007);
		push_op(MODE_INSERT, 16'h0003, 16'h0009);
		write_capacity(2);
		push_op(MODE_INSERT, 16'h0004, 16'h0009);
		write_capacity(1);
		push_op(MODE_INSERT, 16'h0005, 16'h0001);
		push_op(MODE_POP, 16'h0000, 16'h0000);

		random_phase(64, 140, 85);
		random_phase(1, 60, 50);
		random_phase(7, 90, 55);
		random_phase(64, 120, 50);
		random_phase(2, 60, 50);
		random_phase(40, 100, 60);
		random_phase(63, 90, 60);
		random_phase(64, 90, 15);

		wait_drained(END_CYCLES);
		$display("Ran %0d operations: insert %0d, top %0d, pop %0d, remove %0d, update %0d, spare %0d",
			mode_seen[0] + mode_seen[1] + mode_seen[2] + mode_seen[3] + mode_seen[4]
			+ mode_seen[5] + mode_seen[6] + mode_seen[7], mode_seen[0], mode_seen[1],
			mode_seen[2], mode_seen[3], mode_seen[4], mode_seen[5] + mode_seen[6] + mode_seen[7]);
		$display("Statuses ok %0d, empty %0d, full %0d, not found %0d; %0d capacity writes, depth %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], cap_writes, max_depth);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
